[rtl/mpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MQTT packet deframer package
// Shared types and constants for the input queue, parser and result queue.
// ---------------------------------------------------------------------------
package mpd_pkg;

	localparam int LEN_W     = 28;
	localparam int TOPIC_W   = 16;
	localparam int LEN_CNT_W = 3;

	localparam logic [3:0] TYPE_CONNACK = 4'd2;
	localparam logic [3:0] TYPE_PUBLISH = 4'd3;

	localparam logic [1:0] VERDICT_NONE     = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPTED = 2'd1;
	localparam logic [1:0] VERDICT_REFUSED  = 2'd2;

	typedef enum logic [2:0] {
		ROLE_HEADER    = 3'd0,
		ROLE_LENGTH    = 3'd1,
		ROLE_TOPIC_LEN = 3'd2,
		ROLE_TOPIC     = 3'd3,
		ROLE_PAYLOAD   = 3'd4,
		ROLE_OTHER     = 3'd5,
		ROLE_IGNORED   = 3'd6
	} role_t;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_LENGTH,
		PH_BODY
	} phase_t;

	typedef enum logic {
		IT_DATA,
		IT_RESTART
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [7:0]  data;
	} item_t;

	typedef struct packed {
		logic [3:0]       packet_type;
		logic [3:0]       packet_flags;
		role_t            role;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] body_offset;
		logic [LEN_W-1:0] body_length;
		logic             last_of_packet;
		logic [1:0]       connack_verdict;
		logic             publish_ok;
		logic             length_error;
		logic             is_connected;
	} res_t;

endpackage
`default_nettype wire

[rtl/mpd_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MQTT deframer front
// Takes received bytes, tags restart items and holds up to two of them.
// ---------------------------------------------------------------------------
module mpd_front
	import mpd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire logic [7:0] rx_byte,
	input  wire logic       restart,
	output logic            full,
	output logic            valid,
	output item_t           head,
	input  wire logic       take
);

	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;
	item_t      item_in;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign wr_en = push && !full;
	assign rd_en = take && valid;
	assign head  = mem_q[rd_ptr_q];

	always_comb begin
		item_in.kind = restart ? IT_RESTART : IT_DATA;
		item_in.data = rx_byte;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/mpd_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MQTT deframer parser
// Walks header, remaining length and body, one item per cycle unless out_full.
// ---------------------------------------------------------------------------
module mpd_back
	import mpd_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	input  wire item_t in_item,
	input  wire logic  out_full,
	output logic       take,
	output res_t       res
);

	phase_t              phase_q, phase_d;
	logic [3:0]          type_q, type_d;
	logic [3:0]          flags_q, flags_d;
	logic [LEN_W-1:0]    acc_q, acc_d;
	logic [LEN_CNT_W-1:0] cnt_q, cnt_d;
	logic [LEN_W-1:0]    bc_q, bc_d;
	logic [TOPIC_W-1:0]  topic_q, topic_d;
	logic                ackz_q, ackz_d;
	logic                conn_q, conn_d;
	logic                lock_q, lock_d;

	logic [7:0]          b;
	logic                is_restart;
	logic [1:0]          grp;
	logic [LEN_W-1:0]    grp_val;
	logic [LEN_W-1:0]    acc_len;
	logic [LEN_CNT_W-1:0] cnt_next;
	logic                cont;
	logic [LEN_W-1:0]    bc_inc;
	logic                body_last;
	logic                is_pub;
	logic                is_ack;
	logic [TOPIC_W-1:0]  topic_upd;
	logic                ackz_upd;

	assign b          = in_item.data;
	assign is_restart = (in_item.kind == IT_RESTART);
	assign take       = in_valid && !out_full;
	assign cont       = b[7];
	assign is_pub     = (type_q == TYPE_PUBLISH);
	assign is_ack     = (type_q == TYPE_CONNACK);

	// 7-bit group placed by its position, least significant group first
	assign grp = (cnt_q > LEN_CNT_W'(3)) ? 2'd3 : cnt_q[1:0];
	always_comb begin
		case (grp)
			2'd0:    grp_val = {21'd0, b[6:0]};
			2'd1:    grp_val = {14'd0, b[6:0], 7'd0};
			2'd2:    grp_val = {7'd0, b[6:0], 14'd0};
			default: grp_val = {b[6:0], 21'd0};
		endcase
	end
	assign acc_len  = acc_q + grp_val;
	assign cnt_next = LEN_CNT_W'({1'b0, grp}) + LEN_CNT_W'(1);

	assign bc_inc    = bc_q + LEN_W'(1);
	assign body_last = (bc_inc >= acc_q);

	always_comb begin
		topic_upd = topic_q;
		if (is_pub && bc_q == LEN_W'(0)) begin
			topic_upd = {b, 8'h00};
		end else if (is_pub && bc_q == LEN_W'(1)) begin
			topic_upd = {topic_q[15:8], b};
		end
	end
	assign ackz_upd = (is_ack && bc_q == LEN_W'(1)) ? (b == 8'd0) : ackz_q;

	// Next parse phase
	always_comb begin
		phase_d = phase_q;
		if (is_restart) begin
			phase_d = PH_HEADER;
		end else if (!lock_q) begin
			case (phase_q)
				PH_HEADER: phase_d = PH_LENGTH;
				PH_LENGTH: begin
					if (!cont) begin
						phase_d = (acc_len == LEN_W'(0)) ? PH_HEADER : PH_BODY;
					end
				end
				PH_BODY: begin
					if (body_last) begin
						phase_d = PH_HEADER;
					end
				end
				default: phase_d = PH_HEADER;
			endcase
		end
	end

	// Datapath and result
	always_comb begin
		type_d  = type_q;
		flags_d = flags_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		bc_d    = bc_q;
		topic_d = topic_q;
		ackz_d  = ackz_q;
		conn_d  = conn_q;
		lock_d  = lock_q;

		res.role            = ROLE_IGNORED;
		res.body_offset     = '0;
		res.last_of_packet  = 1'b0;
		res.connack_verdict = VERDICT_NONE;
		res.publish_ok      = 1'b0;

		if (is_restart) begin
			type_d  = '0;
			flags_d = '0;
			acc_d   = '0;
			cnt_d   = '0;
			bc_d    = '0;
			topic_d = '0;
			ackz_d  = 1'b0;
			conn_d  = 1'b0;
			lock_d  = 1'b0;
		end else if (!lock_q) begin
			case (phase_q)
				PH_HEADER: begin
					res.role = ROLE_HEADER;
					type_d   = b[7:4];
					flags_d  = b[3:0];
					acc_d    = '0;
					cnt_d    = '0;
					bc_d     = '0;
					topic_d  = '0;
					ackz_d   = 1'b0;
				end
				PH_LENGTH: begin
					res.role = ROLE_LENGTH;
					acc_d    = acc_len;
					cnt_d    = cnt_next;
					if (!cont) begin
						res.last_of_packet = (acc_len == LEN_W'(0));
					end else if (cnt_next >= LEN_CNT_W'(MAX_LENGTH_BYTES)) begin
						lock_d = 1'b1;
					end
				end
				PH_BODY: begin
					res.body_offset = bc_q;
					if (is_pub) begin
						if (bc_q == LEN_W'(0) || bc_q == LEN_W'(1)) begin
							res.role = ROLE_TOPIC_LEN;
						end else if ((bc_q - LEN_W'(2)) < LEN_W'(topic_q)) begin
							res.role = ROLE_TOPIC;
						end else begin
							res.role = ROLE_PAYLOAD;
						end
					end else begin
						res.role = ROLE_OTHER;
					end
					topic_d            = topic_upd;
					ackz_d             = ackz_upd;
					bc_d               = bc_inc;
					res.last_of_packet = body_last;
				end
				default: res.role = ROLE_IGNORED;
			endcase

			// Verdicts use the values this byte leaves behind
			if (res.last_of_packet) begin
				if (is_ack) begin
					if (acc_d >= LEN_W'(2) && ackz_d) begin
						res.connack_verdict = VERDICT_ACCEPTED;
						conn_d              = 1'b1;
					end else begin
						res.connack_verdict = VERDICT_REFUSED;
						conn_d              = 1'b0;
					end
				end else if (is_pub) begin
					res.publish_ok = (acc_d >= LEN_W'(4)) &&
						(acc_d >= LEN_W'({1'b0, topic_d}) + LEN_W'(2));
				end
			end
		end

		res.packet_type  = type_d;
		res.packet_flags = flags_d;
		res.data_byte    = b;
		res.body_length  = acc_d;
		res.length_error = lock_d;
		res.is_connected = conn_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			type_q  <= '0;
			flags_q <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			bc_q    <= '0;
			topic_q <= '0;
			ackz_q  <= 1'b0;
			conn_q  <= 1'b0;
			lock_q  <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			type_q  <= type_d;
			flags_q <= flags_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			bc_q    <= bc_d;
			topic_q <= topic_d;
			ackz_q  <= ackz_d;
			conn_q  <= conn_d;
			lock_q  <= lock_d;
		end
	end

endmodule
`default_nettype wire

[rtl/mpd_res_q.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MQTT deframer result queue
// Two-entry queue that holds parsed items until the consumer pops them.
// ---------------------------------------------------------------------------
module mpd_res_q
	import mpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire res_t wr_item,
	output logic      full,
	output logic      empty,
	output res_t      head,
	input  wire logic pop
);

	res_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en;
	logic       rd_en;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign wr_en = wr && !full;
	assign rd_en = pop && !empty;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/mqtt_packet_deframer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// MQTT packet deframer
// Splits a received byte stream into MQTT packets and tags every byte.
// ---------------------------------------------------------------------------
//  channel   handshake      payload
//  input     push / full    rx_byte, restart
//  result    pop / empty    packet_type .. is_connected (one item per input)
//
//  One item per cycle while the consumer pops; an item is registered in the
//  input queue, then in the result queue. The rate is set by the parser
//  update (length add, body count compare). Each side has a two-entry queue,
//  so a stalled consumer fills the result queue, then the input queue, then
//  raises full. Asynchronous reset clears all parser state; no clearing pass.
// ---------------------------------------------------------------------------
module mqtt_packet_deframer
	import mpd_pkg::*;
#(
	parameter int MAX_LENGTH_BYTES = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        restart,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       packet_type,
	output logic [3:0]       packet_flags,
	output logic [2:0]       byte_role,
	output logic [7:0]       data_byte,
	output logic [LEN_W-1:0] body_offset,
	output logic [LEN_W-1:0] body_length,
	output logic             last_of_packet,
	output logic [1:0]       connack_verdict,
	output logic             publish_ok,
	output logic             length_error,
	output logic             is_connected
);

	logic  item_valid;
	item_t item_head;
	logic  item_take;
	logic  res_full;
	res_t  res_new;
	res_t  res_head;

	mpd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.rx_byte (rx_byte),
		.restart (restart),
		.full    (full),
		.valid   (item_valid),
		.head    (item_head),
		.take    (item_take)
	);

	mpd_back #(
		.MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_valid),
		.in_item  (item_head),
		.out_full (res_full),
		.take     (item_take),
		.res      (res_new)
	);

	mpd_res_q u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (item_take),
		.wr_item (res_new),
		.full    (res_full),
		.empty   (empty),
		.head    (res_head),
		.pop     (pop)
	);

	assign packet_type     = res_head.packet_type;
	assign packet_flags    = res_head.packet_flags;
	assign byte_role       = res_head.role;
	assign data_byte       = res_head.data_byte;
	assign body_offset     = res_head.body_offset;
	assign body_length     = res_head.body_length;
	assign last_of_packet  = res_head.last_of_packet;
	assign connack_verdict = res_head.connack_verdict;
	assign publish_ok      = res_head.publish_ok;
	assign length_error    = res_head.length_error;
	assign is_connected    = res_head.is_connected;

`ifndef SYNTHESIS
	a_verdict_on_connack_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && connack_verdict != VERDICT_NONE |->
			last_of_packet && packet_type == TYPE_CONNACK)
		else $error("connack verdict outside last CONNACK byte");

	a_pub_ok_on_publish_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && publish_ok |-> last_of_packet && packet_type == TYPE_PUBLISH)
		else $error("publish_ok outside last PUBLISH byte");

	a_locked_roles: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && length_error |->
			byte_role == ROLE_LENGTH || byte_role == ROLE_IGNORED)
		else $error("locked parser produced a body or header role");

	a_accept_connects: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && connack_verdict == VERDICT_ACCEPTED |-> is_connected)
		else $error("accepted CONNACK left link disconnected");
`endif

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// MQTT packet deframer testbench
// Sends directed and random broker byte streams through the deframer, with
// random gaps on the push side and random stalls on the pop side. Every
// tagged byte that comes out is compared field by field with a behavioral
// copy of the parser that runs alongside.
// ---------------------------------------------------------------------------
module tb_top;
	import mpd_pkg::*;

	localparam int MAX_LEN_GROUPS = 4;
	localparam int RANDOM_ITEMS   = 850;

	logic             clk     = 1'b0;
	logic             arst_n  = 1'b0;
	logic             push    = 1'b0;
	logic [7:0]       rx_byte = 8'h00;
	logic             restart = 1'b0;
	logic             pop     = 1'b0;
	logic             full;
	logic             empty;
	logic [3:0]       packet_type;
	logic [3:0]       packet_flags;
	logic [2:0]       byte_role;
	logic [7:0]       data_byte;
	logic [LEN_W-1:0] body_offset;
	logic [LEN_W-1:0] body_length;
	logic             last_of_packet;
	logic [1:0]       connack_verdict;
	logic             publish_ok;
	logic             length_error;
	logic             is_connected;

	res_t tags_due[$];
	int   mismatches   = 0;
	int   parsed_count = 0;
	bit   sender_idles = 1'b1;
	bit   reader_idles = 1'b1;

	// parser state as seen by the predictor
	phase_t             phase_q;
	logic [3:0]         cur_type;
	logic [3:0]         cur_flags;
	logic [LEN_W-1:0]   rem_len;
	logic [LEN_W-1:0]   body_idx;
	logic [LEN_CNT_W-1:0] len_groups;
	logic [TOPIC_W-1:0] topic_len;
	logic               connack_zero;
	logic               connected;
	logic               locked;

	mqtt_packet_deframer #(.MAX_LENGTH_BYTES(MAX_LEN_GROUPS)) uut (.*);

	always #4 clk = ~clk;

	function automatic void clear_parser();
		phase_q      = PH_HEADER;
		cur_type     = '0;
		cur_flags    = '0;
		rem_len      = '0;
		body_idx     = '0;
		len_groups   = '0;
		topic_len    = '0;
		connack_zero = 1'b0;
		connected    = 1'b0;
		locked       = 1'b0;
	endfunction

	function automatic void close_packet(inout res_t t);
		if (cur_type == TYPE_CONNACK) begin
			if (rem_len >= 2 && connack_zero) begin
				t.connack_verdict = VERDICT_ACCEPTED;
				connected = 1'b1;
			end else begin
				// refused: link gets dropped
				t.connack_verdict = VERDICT_REFUSED;
				connected = 1'b0;
			end
		end else if (cur_type == TYPE_PUBLISH) begin
			t.publish_ok = (rem_len >= 4) && (32'(rem_len) >= 32'd2 + 32'(topic_len));
		end
		t.last_of_packet = 1'b1;
		phase_q = PH_HEADER;
	endfunction

	// Tags one byte and advances the parser state.
	function automatic res_t tag_rx_byte(input logic [7:0] b, input logic rst);
		res_t t;
		logic [31:0] grp;
		t = '0;
		t.role = ROLE_IGNORED;
		if (rst) begin
			clear_parser();
		end else if (locked) begin
			t.role = ROLE_IGNORED;
		end else if (phase_q == PH_HEADER) begin
			t.role       = ROLE_HEADER;
			cur_type     = b[7:4];
			cur_flags    = b[3:0];
			rem_len      = '0;
			len_groups   = '0;
			body_idx     = '0;
			topic_len    = '0;
			connack_zero = 1'b0;
			phase_q      = PH_LENGTH;
		end else if (phase_q == PH_LENGTH) begin
			t.role = ROLE_LENGTH;
			if (len_groups > 3)
				len_groups = 3;
			grp        = 32'(b[6:0]) << (7 * len_groups);
			rem_len    = rem_len + grp[LEN_W-1:0];
			len_groups = len_groups + 1'b1;
			if (!b[7]) begin
				if (rem_len == 0)
					close_packet(t);
				else
					phase_q = PH_BODY;
			end else if (len_groups >= MAX_LEN_GROUPS) begin
				locked = 1'b1;
			end
		end else begin
			t.body_offset = body_idx;
			if (cur_type == TYPE_PUBLISH) begin
				if (body_idx == 0) begin
					t.role    = ROLE_TOPIC_LEN;
					topic_len = {b, 8'h00};
				end else if (body_idx == 1) begin
					t.role         = ROLE_TOPIC_LEN;
					topic_len[7:0] = b;
				end else if (32'(body_idx) - 32'd2 < 32'(topic_len)) begin
					t.role = ROLE_TOPIC;
				end else begin
					t.role = ROLE_PAYLOAD;
				end
			end else begin
				t.role = ROLE_OTHER;
				if (cur_type == TYPE_CONNACK && body_idx == 1)
					connack_zero = (b == 8'h00);
			end
			body_idx = body_idx + 1'b1;
			if (body_idx >= rem_len)
				close_packet(t);
		end
		t.packet_type  = cur_type;
		t.packet_flags = cur_flags;
		t.data_byte    = b;
		t.body_length  = rem_len;
		t.length_error = locked;
		t.is_connected = connected;
		return t;
	endfunction

	task automatic send_item(input logic [7:0] b, input logic rst);
		int gap;
		res_t t;
		gap = sender_idles ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push    <= 1'b1;
		rx_byte <= b;
		restart <= rst;
		do @(posedge clk); while (full !== 1'b0);
		t = tag_rx_byte(b, rst);
		tags_due.push_back(t);
		if (t.role != ROLE_IGNORED)
			parsed_count++;
	endtask

	// bytes sit in the low n bytes of seq, first byte highest
	task automatic send_bytes(input logic [255:0] seq, input int n);
		int k;
		for (k = 0; k < n; k++)
			send_item(seq[8 * (n - 1 - k) +: 8], 1'b0);
	endtask

	// holds off the sender until every pushed item has been checked
	task automatic wait_all_tagged();
		push <= 1'b0;
		@(posedge clk);
		while (tags_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [27:0] want,
			input logic [27:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic test_connack();
		send_bytes({8'h20, 8'h02, 8'h00, 8'h00}, 4);
		// zero remaining length: refused on the length byte
		send_bytes({8'h20, 8'h00}, 2);
		send_bytes({8'hC0, 8'h00}, 2);
	endtask

	task automatic test_publish();
		send_bytes({8'h3F, 8'h05, 8'h00, 8'h01, 8'h41, 8'h42, 8'h43}, 7);
		// topic length runs past the end of the body
		send_bytes({8'h3A, 8'h03, 8'hFF, 8'hFF, 8'h00}, 5);
	endtask

	task automatic test_length_limits();
		send_bytes({8'hF0, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h5A}, 6);
		send_item(8'hFF, 1'b1);
		// fourth length group still continued: parser locks until restart
		send_bytes({8'h30, 8'h80, 8'h80, 8'h80, 8'h80, 8'hAA}, 6);
		send_item(8'h00, 1'b1);
	endtask

	task automatic send_packet(input bit truncate);
		logic [7:0]  pkt[$];
		logic [3:0]  kind;
		logic [15:0] tlen;
		int pick, body_len, n_groups, cut, k;
		pick = $urandom_range(0, 9);
		kind = (pick < 3) ? TYPE_CONNACK : (pick < 7) ? TYPE_PUBLISH : 4'($urandom);
		if ($urandom_range(0, 39) == 0)
			body_len = $urandom_range(128, 200);
		else if (kind == TYPE_CONNACK && $urandom_range(0, 3) != 0)
			body_len = 2;
		else
			body_len = $urandom_range(0, 12);
		if ($urandom_range(0, 7) == 0)
			tlen = 16'($urandom);
		else
			tlen = 16'($urandom_range(0, (body_len > 2) ? body_len - 2 : 0));
		pkt.push_back({kind, 4'($urandom)});
		// sometimes padded with zero groups up to the limit
		n_groups = (body_len > 127) ? 2 : 1;
		if ($urandom_range(0, 3) == 0)
			n_groups = $urandom_range(n_groups, MAX_LEN_GROUPS);
		for (k = 0; k < n_groups; k++)
			pkt.push_back({k != n_groups - 1, 7'(body_len >> (7 * k))});
		for (k = 0; k < body_len; k++) begin
			if (kind == TYPE_PUBLISH && k < 2)
				pkt.push_back(k == 0 ? tlen[15:8] : tlen[7:0]);
			else if (kind == TYPE_CONNACK && k == 1 && $urandom_range(0, 3) != 0)
				pkt.push_back(8'h00);
			else
				pkt.push_back(8'($urandom));
		end
		cut = truncate ? $urandom_range(1, pkt.size()) : pkt.size();
		for (k = 0; k < cut; k++)
			send_item(pkt[k], 1'b0);
		if (truncate)
			send_item(8'($urandom), 1'b1);
	endtask

	task automatic test_random_stream();
		int pick;
		bit paused;
		paused = 1'b0;
		parsed_count = 0;
		while (parsed_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 15) == 0)
				sender_idles = ~sender_idles;
			pick = $urandom_range(0, 19);
			if (pick < 15) begin
				send_packet(1'b0);
			end else if (pick < 17) begin
				send_packet(1'b1);
			end else if (pick < 19) begin
				// overlong length, a few locked bytes, then restart
				send_item(8'($urandom), 1'b0);
				repeat (MAX_LEN_GROUPS) send_item(8'($urandom) | 8'h80, 1'b0);
				repeat ($urandom_range(0, 5)) send_item(8'($urandom), 1'b0);
				send_item(8'($urandom), 1'b1);
			end else begin
				// raw noise could leave a huge length pending, so resync
				repeat ($urandom_range(1, 6)) send_item(8'($urandom), 1'b0);
				send_item(8'($urandom), 1'b1);
			end
			if (!paused && parsed_count >= RANDOM_ITEMS / 2) begin
				paused = 1'b1;
				wait_all_tagged();
			end
		end
	endtask

	initial begin : result_checker
		res_t want;
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 63) == 0)
				reader_idles = ~reader_idles;
			stall = reader_idles ? $urandom_range(0, 10) : 0;
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty !== 1'b0);
			if (tags_due.size() == 0) begin
				$display("%0t: unexpected item, expected none actual data_byte %0h role %0d",
					$time, data_byte, byte_role);
				mismatches++;
			end else begin
				want = tags_due.pop_front();
				check_field("packet_type", want.packet_type, packet_type);
				check_field("packet_flags", want.packet_flags, packet_flags);
				check_field("byte_role", want.role, byte_role);
				check_field("data_byte", want.data_byte, data_byte);
				check_field("body_offset", want.body_offset, body_offset);
				check_field("body_length", want.body_length, body_length);
				check_field("last_of_packet", want.last_of_packet, last_of_packet);
				check_field("connack_verdict", want.connack_verdict, connack_verdict);
				check_field("publish_ok", want.publish_ok, publish_ok);
				check_field("length_error", want.length_error, length_error);
				check_field("is_connected", want.is_connected, is_connected);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("mqtt_packet_deframer verification failed");
		$finish;
	end

	initial begin
		clear_parser();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_connack();
		wait_all_tagged();
		test_publish();
		test_length_limits();
		wait_all_tagged();
		test_random_stream();
		wait_all_tagged();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("mqtt_packet_deframer verification clean");
		else
			$display("mqtt_packet_deframer verification failed");
		$finish;
	end

endmodule

[files.f]
rtl/mpd_pkg.sv
rtl/mpd_front.sv
rtl/mpd_back.sv
rtl/mpd_res_q.sv
rtl/mqtt_packet_deframer.sv
tb/sv/tb_top.sv
